[design/ssp_pkg.sv]
// ----------------------------------------------------------------------------
// Surface stack position package
// Shared types, codes and default sizes of the surface stack position unit.
// ----------------------------------------------------------------------------
package ssp_pkg;

  // Default sizes, used as parameter defaults on the top level, and the neighbor count.
  localparam int MaxSurfacesDef = 8;
  localparam int MaxPointsDef   = 1024;
  localparam int Neighbors      = 4;

  // Field widths fixed by the item format.
  localparam int CoordW  = 24;
  localparam int ActionW = 2;
  localparam int SidxW   = 3;
  localparam int PosW    = 4;
  localparam int CfgW    = 4;
  localparam int AbsW    = CoordW + 1;
  localparam int DistW   = 2 * AbsW;
  localparam int ZSumW   = CoordW + 2;

  // Action codes carried by an input beat.
  typedef enum logic [ActionW-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  // Sequencer states of the query scan.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SELECT,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // One stored surface point.
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  // Tag that travels with a point read through the distance pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tag_t;

  // Per-surface decision from the neighbor unit.
  typedef struct packed {
    logic valid;
    logic above;
  } res_t;

endpackage

[design/ssp_if.sv]
// ----------------------------------------------------------------------------
// Surface stack position channels
// Valid/ready channels for input items, results and the configuration write.
// ----------------------------------------------------------------------------
interface ssp_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic [2:0]                  surface_index;
  logic signed [23:0]          coord_x;
  logic signed [23:0]          coord_y;
  logic signed [23:0]          coord_z;
  modport source (output valid, action, surface_index, coord_x, coord_y, coord_z,
                  input ready);
  modport sink (input valid, action, surface_index, coord_x, coord_y, coord_z,
                output ready);
endinterface

interface ssp_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] position;
  modport source (output valid, position, input ready);
  modport sink (input valid, position, output ready);
endinterface

interface ssp_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[design/surface_stack_position_knn_unit.sv]
// Load and clear beats leave the unit idle, so it stays ready for the next beat.
// A query scans the surfaces, passing over empty ones; for each loaded surface there
// is one point memory read per cycle, a three-stage distance pipeline, a slot update
// and a height test. No input beat is taken until the query result is registered.
// Reset empties all surfaces and sets surface_count to 1; point memory is not cleared.
// ----------------------------------------------------------------------------
// Surface stack position unit
// Four-nearest-neighbor position of a point within a stack of surfaces.
// ----------------------------------------------------------------------------
module surface_stack_position_knn_unit #(
  parameter int MaxSurfaces = ssp_pkg::MaxSurfacesDef,
  parameter int MaxPoints   = ssp_pkg::MaxPointsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ssp_in_if.sink   in_i,
  ssp_out_if.source out_o,
  ssp_cfg_if.sink  cfg_i
);
  import ssp_pkg::*;

  localparam int Depth = MaxSurfaces * MaxPoints;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SIdxW = (MaxSurfaces > 1) ? $clog2(MaxSurfaces) : 1;
  localparam int SCntW = $clog2(MaxSurfaces + 1);
  localparam int PIdxW = $clog2(MaxPoints);
  localparam int PCntW = $clog2(MaxPoints + 1);

  state_e                   state_q, state_d;
  logic [PCntW-1:0]         count_q [MaxSurfaces];
  logic [CfgW-1:0]          scount_q;
  logic [SCntW-1:0]         surf_q, surf_d, limit_q, limit_d;
  logic [PIdxW-1:0]         pt_q, pt_d;
  logic [PosW-1:0]          pos_q, pos_d;
  logic                     ovalid_q, ovalid_d;
  logic [PosW-1:0]          opos_q, opos_d;
  logic signed [CoordW-1:0] qx_q, qy_q, qz_q;

  logic             in_acc, is_load, is_query, is_clear, load_ok;
  logic [SIdxW-1:0] load_surf, cur_surf;
  logic [PCntW-1:0] cur_count;
  logic             mem_we;
  logic [AddrW-1:0] waddr, raddr;
  point_t           wdata, rdata, dpt;
  tag_t             rtag, mtag, dtag;
  logic [DistW-1:0] sq_dist;
  logic signed [CoordW-1:0] dz;
  res_t             res;

  // Input beat decode.
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_load    = in_acc && (in_i.action == ACT_LOAD);
  assign is_query   = in_acc && (in_i.action == ACT_QUERY);
  assign is_clear   = in_acc && (in_i.action == ACT_CLEAR);
  assign load_surf  = SIdxW'(in_i.surface_index);
  assign load_ok    = (32'(in_i.surface_index) < MaxSurfaces)
                      && (32'(count_q[load_surf]) < MaxPoints);

  assign mem_we = is_load && load_ok;
  assign waddr  = AddrW'(32'(load_surf) * MaxPoints + 32'(count_q[load_surf]));
  assign wdata  = '{x: in_i.coord_x, y: in_i.coord_y, z: in_i.coord_z};

  assign cur_surf  = surf_q[SIdxW-1:0];
  assign cur_count = count_q[cur_surf];
  assign raddr     = AddrW'(32'(cur_surf) * MaxPoints + 32'(pt_q));

  // Configuration register.
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scount_q <= CfgW'(1);
    end else if (cfg_i.valid) begin
      scount_q <= cfg_i.data;
    end
  end

  // Point counts per surface.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < MaxSurfaces; s++) begin
        count_q[s] <= '0;
      end
    end else if (is_clear) begin
      for (int s = 0; s < MaxSurfaces; s++) begin
        count_q[s] <= '0;
      end
    end else if (mem_we) begin
      count_q[load_surf] <= count_q[load_surf] + PCntW'(1);
    end
  end

  // Query point.
  always_ff @(posedge clk_i) begin
    if (is_query) begin
      qx_q <= in_i.coord_x;
      qy_q <= in_i.coord_y;
      qz_q <= in_i.coord_z;
    end
  end

  // Scan sequencer: next state and outputs.
  always_comb begin
    state_d  = state_q;
    surf_d   = surf_q;
    limit_d  = limit_q;
    pt_d     = pt_q;
    pos_d    = pos_q;
    ovalid_d = ovalid_q && !out_o.ready;
    opos_d   = opos_q;
    rtag     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (is_query) begin
          surf_d  = '0;
          pos_d   = '0;
          limit_d = (32'(scount_q) > MaxSurfaces) ? SCntW'(MaxSurfaces)
                                                  : SCntW'(scount_q);
          state_d = ST_SELECT;
        end
      end
      ST_SELECT: begin
        if (surf_q == limit_q) begin
          state_d = ST_DONE;
        end else if (cur_count == '0) begin
          surf_d = surf_q + SCntW'(1);
        end else begin
          pt_d    = '0;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        rtag.valid = 1'b1;
        rtag.first = (pt_q == '0);
        rtag.last  = (32'(pt_q) + 1 == 32'(cur_count));
        pt_d       = pt_q + PIdxW'(1);
        if (rtag.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (res.valid) begin
          if (res.above) begin
            if (surf_q == '0) begin
              pos_d = PosW'(1);
            end else if (qz_q != '0) begin
              pos_d = pos_q + PosW'(1);
            end
          end
          surf_d  = surf_q + SCntW'(1);
          state_d = ST_SELECT;
        end
      end
      ST_DONE: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          opos_d   = pos_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      surf_q   <= '0;
      limit_q  <= '0;
      pt_q     <= '0;
      pos_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      surf_q   <= surf_d;
      limit_q  <= limit_d;
      pt_q     <= pt_d;
      pos_q    <= pos_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opos_q <= opos_d;
  end

  assign out_o.valid    = ovalid_q;
  assign out_o.position = opos_q;

  // Datapath.
  ssp_point_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rtag_i  (rtag),
    .rdata_o (rdata),
    .rtag_o  (mtag)
  );

  assign dpt = rdata;

  ssp_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_i   (dpt),
    .tag_i  (mtag),
    .qx_i   (qx_q),
    .qy_i   (qy_q),
    .dist_o (sq_dist),
    .z_o    (dz),
    .tag_o  (dtag)
  );

  ssp_knn u_knn (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .dist_i (sq_dist),
    .z_i    (dz),
    .tag_i  (dtag),
    .qz_i   (qz_q),
    .res_o  (res)
  );

endmodule

[design/ssp_point_mem.sv]
// ----------------------------------------------------------------------------
// Surface point memory
// Single-port-write, single-port-read point store with registered read data.
// ----------------------------------------------------------------------------
module ssp_point_mem #(
  parameter int Depth = 8192,
  parameter int AddrW = 13
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  ssp_pkg::point_t   wdata_i,
  input  logic [AddrW-1:0]  raddr_i,
  input  ssp_pkg::tag_t     rtag_i,
  output ssp_pkg::point_t   rdata_o,
  output ssp_pkg::tag_t     rtag_o
);
  import ssp_pkg::*;

  point_t mem_q [Depth];
  point_t rdata_q;
  tag_t   rtag_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (rtag_i.valid) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // The tag follows the read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rtag_q <= '0;
    end else begin
      rtag_q <= rtag_i;
    end
  end

  assign rdata_o = rdata_q;
  assign rtag_o  = rtag_q;

endmodule

[design/ssp_dist.sv]
// ----------------------------------------------------------------------------
// Squared distance pipeline
// Three stages: absolute differences, squares, and their sum.
// ----------------------------------------------------------------------------
module ssp_dist (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ssp_pkg::point_t                     pt_i,
  input  ssp_pkg::tag_t                       tag_i,
  input  logic signed [ssp_pkg::CoordW-1:0]   qx_i,
  input  logic signed [ssp_pkg::CoordW-1:0]   qy_i,
  output logic [ssp_pkg::DistW-1:0]           dist_o,
  output logic signed [ssp_pkg::CoordW-1:0]   z_o,
  output ssp_pkg::tag_t                       tag_o
);
  import ssp_pkg::*;

  logic signed [AbsW-1:0]   dx, dy;
  logic [AbsW-1:0]          ax_q, ay_q;
  logic [DistW-1:0]         sx_q, sy_q, sum_q;
  logic signed [CoordW-1:0] z1_q, z2_q, z3_q;
  tag_t                     t1_q, t2_q, t3_q;

  // Signed differences, one bit wider than a coordinate.
  assign dx = AbsW'(pt_i.x) - AbsW'(qx_i);
  assign dy = AbsW'(pt_i.y) - AbsW'(qy_i);

  // Data stages.
  always_ff @(posedge clk_i) begin
    ax_q  <= dx[AbsW-1] ? AbsW'(-dx) : AbsW'(dx);
    ay_q  <= dy[AbsW-1] ? AbsW'(-dy) : AbsW'(dy);
    z1_q  <= pt_i.z;
    sx_q  <= DistW'(ax_q) * DistW'(ax_q);
    sy_q  <= DistW'(ay_q) * DistW'(ay_q);
    z2_q  <= z1_q;
    sum_q <= sx_q + sy_q;
    z3_q  <= z2_q;
  end

  // Tag stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
      t3_q <= '0;
    end else begin
      t1_q <= tag_i;
      t2_q <= t1_q;
      t3_q <= t2_q;
    end
  end

  assign dist_o = sum_q;
  assign z_o    = z3_q;
  assign tag_o  = t3_q;

endmodule

[design/ssp_knn.sv]
// ----------------------------------------------------------------------------
// Nearest neighbor slots
// Keeps the four nearest points of one surface and tests the mean height.
// ----------------------------------------------------------------------------
module ssp_knn (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [ssp_pkg::DistW-1:0]           dist_i,
  input  logic signed [ssp_pkg::CoordW-1:0]   z_i,
  input  ssp_pkg::tag_t                       tag_i,
  input  logic signed [ssp_pkg::CoordW-1:0]   qz_i,
  output ssp_pkg::res_t                       res_o
);
  import ssp_pkg::*;

  logic [DistW-1:0]         dist_q [Neighbors];
  logic signed [CoordW-1:0] z_q    [Neighbors];
  logic [1:0]               far;
  logic                     eval_q;
  res_t                     res_q;
  logic signed [ZSumW-1:0]  zsum, lhs;

  // First slot holding the largest distance.
  always_comb begin
    far = 2'd0;
    for (int k = 1; k < Neighbors; k++) begin
      if (dist_q[k] > dist_q[far]) begin
        far = 2'(k);
      end
    end
  end

  // Seed on the first point, replace the farthest slot on a closer one.
  always_ff @(posedge clk_i) begin
    if (tag_i.valid) begin
      if (tag_i.first) begin
        for (int k = 0; k < Neighbors; k++) begin
          dist_q[k] <= dist_i;
          z_q[k]    <= z_i;
        end
      end else if (dist_i < dist_q[far]) begin
        dist_q[far] <= dist_i;
        z_q[far]    <= z_i;
      end
    end
  end

  // Mean height test as 4*z against the sum of the slot heights.
  assign zsum = ZSumW'(z_q[0]) + ZSumW'(z_q[1]) + ZSumW'(z_q[2]) + ZSumW'(z_q[3]);
  assign lhs  = {qz_i, 2'b00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_q <= 1'b0;
      res_q  <= '0;
    end else begin
      eval_q      <= tag_i.valid && tag_i.last;
      res_q.valid <= eval_q;
      res_q.above <= lhs >= zsum;
    end
  end

  assign res_o = res_q;

endmodule

[design/ssp_checker.sv]
// ----------------------------------------------------------------------------
// Surface stack position checker
// Port-level assertions on the unit's channels, bound to the top level.
// ----------------------------------------------------------------------------
module ssp_checker #(
  parameter int MaxSurfaces = ssp_pkg::MaxSurfacesDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_action,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_position
);
  import ssp_pkg::*;

  // A stalled result beat holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_position))
    else $error("result beat changed while stalled");

  // A query keeps the input side closed on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_action == ACT_QUERY |=> !in_ready)
    else $error("input accepted during a query");

  // Loads and clears leave the input side open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_action == ACT_LOAD || in_action == ACT_CLEAR)
    |=> in_ready)
    else $error("load or clear did not complete in one cycle");

  // The position never exceeds the number of surfaces.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> 32'(out_position) <= MaxSurfaces || MaxSurfaces > 15)
    else $error("position beyond surface count");

endmodule

bind surface_stack_position_knn_unit ssp_checker #(
  .MaxSurfaces (MaxSurfaces)
) u_ssp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .in_action    (in_i.action),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .out_position (out_o.position)
);
